// ===== sv/gdu_pkg.sv =====
// Shared types, constants and calendar helper functions for the Gregorian date unit.
// No dependencies. Used by gdu_if.sv, gdu_calc.sv and gregorian_date_unit.sv.

package gdu_pkg;

  // Width of the year field on the ports, and the year range honored inside
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned YEAR_BITS = 16;

  localparam logic [YEAR_W-1:0] YEAR_MASK = (YEAR_BITS >= YEAR_W) ? {YEAR_W{1'b1}} :
                                            YEAR_W'((33'd1 << YEAR_BITS) - 33'd1);
  localparam logic [32:0] YEAR_MAX = (33'd1 << YEAR_BITS) - 33'd1;

  // Divisibility by 25 via the modular inverse of 25 mod 2^16
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'(65535 / 25);

  localparam logic [8:0] DAYS_YEAR      = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;

  typedef enum logic [2:0] {
    OP_VALIDATE = 3'd0,
    OP_NEXT     = 3'd1,
    OP_PREV     = 3'd2,
    OP_TO_DOY   = 3'd3,
    OP_FROM_DOY = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [4:0]        in_day;
    logic [3:0]        in_month;
    logic [YEAR_W-1:0] in_year;
    logic [8:0]        day_number;
  } item_t;

  typedef struct packed {
    logic [4:0]        out_day;
    logic [3:0]        out_month;
    logic [YEAR_W-1:0] out_year;
    logic [8:0]        out_day_number;
    logic              out_valid;
  } result_t;

  // 4/100/400 rule: leap = div4 && (!div100 || div400)
  //                      = div4 && (!div25 || div16)
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(y) * 32'(INV25);
    div25 = (prod[15:0] <= DIV25_LIMIT);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Length of month m; 0 for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                        n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the year before the first of month m, leap day included
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// ===== sv/gdu_if.sv =====
// Valid/ready channel interfaces for the Gregorian date unit: item in, result out.
// Depends on gdu_pkg for the year width.

interface gdu_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                operation;
  logic [4:0]                in_day;
  logic [3:0]                in_month;
  logic [gdu_pkg::YEAR_W-1:0] in_year;
  logic [8:0]                day_number;

  modport source (output valid, operation, in_day, in_month, in_year, day_number,
                  input ready);
  modport sink   (input valid, operation, in_day, in_month, in_year, day_number,
                  output ready);
endinterface

interface gdu_out_if;
  logic                      valid;
  logic                      ready;
  logic [4:0]                out_day;
  logic [3:0]                out_month;
  logic [gdu_pkg::YEAR_W-1:0] out_year;
  logic [8:0]                out_day_number;
  logic                      out_valid;

  modport source (output valid, out_day, out_month, out_year, out_day_number, out_valid,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, out_day_number, out_valid,
                  output ready);
endinterface

// ===== sv/gdu_calc.sv =====
// Combinational date arithmetic for one item: validate, step, day-of-year conversions.
// Depends on gdu_pkg (types, month tables, leap test).

module gdu_calc (
  input  gdu_pkg::item_t   item_i,
  output gdu_pkg::result_t res_o
);

  gdu_pkg::op_e                op;
  logic [gdu_pkg::YEAR_W-1:0]  y;
  logic [4:0]                  d;
  logic [3:0]                  m;
  logic [8:0]                  h;
  logic                        leap;
  logic [4:0]                  len;
  logic                        date_ok;
  logic [8:0]                  total;
  logic                        doy_ok;
  logic [3:0]                  past_cnt;
  logic [3:0]                  doy_month;
  logic [8:0]                  doy_day;

  always_comb begin
    op   = gdu_pkg::op_e'(item_i.operation);
    y    = item_i.in_year & gdu_pkg::YEAR_MASK;
    d    = item_i.in_day;
    m    = item_i.in_month;
    h    = item_i.day_number;
    leap = gdu_pkg::is_leap(y);
    len  = gdu_pkg::month_len(m, leap);

    date_ok = (y != '0) && (m >= 4'd1) && (m <= 4'd12) && (d != 5'd0) && (d <= len);

    // Day number to month: count month ends already passed (parallel compares)
    total    = leap ? gdu_pkg::DAYS_LEAP_YEAR : gdu_pkg::DAYS_YEAR;
    doy_ok   = (y != '0) && (h != 9'd0) && (h <= total);
    past_cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (h > gdu_pkg::days_before(4'(k + 1), leap)) begin
        past_cnt = past_cnt + 4'd1;
      end
    end
    doy_month = past_cnt + 4'd1;
    doy_day   = h - gdu_pkg::days_before(doy_month, leap);

    // Default: pass the date through, flagged invalid
    res_o.out_day        = d;
    res_o.out_month      = m;
    res_o.out_year       = y;
    res_o.out_day_number = 9'd0;
    res_o.out_valid      = 1'b0;

    unique case (op)
      gdu_pkg::OP_VALIDATE: begin
        res_o.out_valid = date_ok;
      end
      gdu_pkg::OP_NEXT: begin
        if (date_ok) begin
          if (d < len) begin
            res_o.out_day   = d + 5'd1;
            res_o.out_valid = 1'b1;
          end else if (m < 4'd12) begin
            res_o.out_day   = 5'd1;
            res_o.out_month = m + 4'd1;
            res_o.out_valid = 1'b1;
          end else if ({17'd0, y} < gdu_pkg::YEAR_MAX) begin
            res_o.out_day   = 5'd1;
            res_o.out_month = 4'd1;
            res_o.out_year  = y + 1'b1;
            res_o.out_valid = 1'b1;
          end
        end
      end
      gdu_pkg::OP_PREV: begin
        if (date_ok) begin
          if (d > 5'd1) begin
            res_o.out_day   = d - 5'd1;
            res_o.out_valid = 1'b1;
          end else if (m > 4'd1) begin
            res_o.out_day   = gdu_pkg::month_len(m - 4'd1, leap);
            res_o.out_month = m - 4'd1;
            res_o.out_valid = 1'b1;
          end else if (y > gdu_pkg::YEAR_W'(1)) begin
            res_o.out_day   = 5'd31;
            res_o.out_month = 4'd12;
            res_o.out_year  = y - 1'b1;
            res_o.out_valid = 1'b1;
          end
        end
      end
      gdu_pkg::OP_TO_DOY: begin
        if (date_ok) begin
          res_o.out_day_number = gdu_pkg::days_before(m, leap) + 9'(d);
          res_o.out_valid      = 1'b1;
        end
      end
      gdu_pkg::OP_FROM_DOY: begin
        res_o.out_day   = 5'd0;
        res_o.out_month = 4'd0;
        res_o.out_year  = '0;
        if (doy_ok) begin
          res_o.out_day   = doy_day[4:0];
          res_o.out_month = doy_month;
          res_o.out_year  = y;
          res_o.out_valid = 1'b1;
        end
      end
      default: begin
        // undefined operation codes: all zero
        res_o.out_day   = 5'd0;
        res_o.out_month = 4'd0;
        res_o.out_year  = '0;
      end
    endcase
  end

endmodule

// ===== sv/gregorian_date_unit.sv =====
// Registers: an item is captured in the input register, then its result in the result register.
// Throughput: one item per cycle unless out stalls; only loop: table/compare logic in gdu_calc.
// Backpressure: both stages hold while out is stalled; input stays ready while a stage is free.
// Reset (rst_ni low, async): both stage valid flags clear; payload registers are not reset.
// Depends on gdu_pkg, gdu_if (channels) and gdu_calc.

module gregorian_date_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdu_in_if.sink    in_ch_i,
  gdu_out_if.source out_ch_o
);

  // Stage 1: input item register
  logic             s1_valid_q, s1_valid_d;
  gdu_pkg::item_t   s1_item_q;
  // Stage 2: result register
  logic             s2_valid_q, s2_valid_d;
  gdu_pkg::result_t s2_res_q;
  gdu_pkg::result_t calc_res;
  gdu_pkg::item_t   in_item;

  logic s1_en;  // stage 1 may load this cycle
  logic s2_en;  // stage 2 may load this cycle

  // A stage loads when it is empty or its contents move on this cycle
  assign s2_en = !s2_valid_q || out_ch_o.ready;
  assign s1_en = !s1_valid_q || s2_en;

  assign in_ch_i.ready = s1_en;

  assign in_item = '{operation:  in_ch_i.operation,
                     in_day:     in_ch_i.in_day,
                     in_month:   in_ch_i.in_month,
                     in_year:    in_ch_i.in_year,
                     day_number: in_ch_i.day_number};

  assign s1_valid_d = s1_en ? in_ch_i.valid : s1_valid_q;
  assign s2_valid_d = s2_en ? s1_valid_q    : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers, loaded only on a beat into the stage
  always_ff @(posedge clk_i) begin
    if (s1_en && in_ch_i.valid) begin
      s1_item_q <= in_item;
    end
    if (s2_en && s1_valid_q) begin
      s2_res_q <= calc_res;
    end
  end

  // All date arithmetic sits between the two registers
  gdu_calc u_calc (
    .item_i (s1_item_q),
    .res_o  (calc_res)
  );

  assign out_ch_o.valid          = s2_valid_q;
  assign out_ch_o.out_day        = s2_res_q.out_day;
  assign out_ch_o.out_month      = s2_res_q.out_month;
  assign out_ch_o.out_year       = s2_res_q.out_year;
  assign out_ch_o.out_day_number = s2_res_q.out_day_number;
  assign out_ch_o.out_valid      = s2_res_q.out_valid;

`ifndef SYNTHESIS
  // A held stage-1 item is neither dropped nor altered
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_en |=> s1_valid_q && $stable(s1_item_q))
    else $error("stage 1 item lost while stalled");

  // A valid result always names a real date
  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_res_q.out_valid |->
      s2_res_q.out_day != 5'd0 && s2_res_q.out_month >= 4'd1 &&
      s2_res_q.out_month <= 4'd12 && s2_res_q.out_year != '0)
    else $error("valid result with impossible date");

  // A day-of-year result is only produced for a valid date, and within 366
  a_doy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_res_q.out_day_number != 9'd0 |->
      s2_res_q.out_valid && s2_res_q.out_day_number <= gdu_pkg::DAYS_LEAP_YEAR)
    else $error("day number out of range or unflagged");

  // An item is taken only while a stage can absorb it
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch_i.valid && in_ch_i.ready |-> !(s1_valid_q && s2_valid_q && !out_ch_o.ready))
    else $error("input beat taken with pipeline full");
`endif

endmodule
